[rtl/idb_pkg.sv]
package idb_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_MODE     = 2'd0;
   localparam logic [1:0] CSR_KEY_SEED = 2'd1;
   localparam logic [1:0] CSR_BLOCK_LEN = 2'd2;

   // Descramble schemes
   typedef enum logic [1:0] {
      MODE_PREFIX = 2'd0,
      MODE_POSKEY = 2'd1,
      MODE_ADDKEY = 2'd2,
      MODE_ROTWORD = 2'd3
   } mode_type;

   localparam logic [31:0] PREFIX_LEN = 32'd25;
   localparam logic [31:0] KEY_A      = 32'hBD3ACCDD;
   localparam logic [31:0] KEY_B      = 32'h915C1A4C;
   localparam logic [7:0]  BYTE_MASK  = 8'hFF;

   // One group of result beats caused by one input byte
   typedef struct packed {
      logic [3:0][7:0] data;      // beat i carries data[i]
      logic [1:0]      last_idx;  // index of the final beat
      logic            blk;       // group closes the block
   } run_type;

endpackage

[rtl/idb_req_if.sv]
interface idb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

[rtl/idb_rsp_if.sv]
interface idb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       block_end;
   logic       run_end;

   modport source (output valid, output out_byte, output block_end, output run_end,
                   input ready);
   modport sink (input valid, input out_byte, input block_end, input run_end,
                 output ready);
endinterface

[rtl/idb_in_stage.sv]
module idb_in_stage (
   input  logic       clock,
   input  logic       reset,
   idb_req_if.sink    req_if,
   input  logic       item_take,
   output logic       item_valid,
   output logic [7:0] item_byte
);
   import idb_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       accept;

   // Take a new beat when empty or when the held byte moves on
   assign req_if.ready = !valid_ff || item_take;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_if.in_byte & BYTE_MASK;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

[rtl/idb_descramble.sv]
module idb_descramble (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   input  logic             item_valid,
   input  logic [7:0]       item_byte,
   input  logic             out_free,
   output logic             item_take,
   output logic             run_load,
   output idb_pkg::run_type run
);
   import idb_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [31:0] seed_ff, seed_in;
   logic [31:0] blen_ff, blen_in;
   logic [31:0] pos_ff, pos_in;
   logic        phase_ff, phase_in;
   logic [7:0]  add_key_ff, add_key_in;
   logic [2:0][7:0] win_ff, win_in;

   logic        last;
   logic        early;
   logic        no_result;
   logic        csr_hit;
   logic [7:0]  prefix_key, k0, k1, pos_ks, inc, cur_key;
   logic [31:0] word, diff, rot, dec;
   run_type     run_c;

   // Block position tests
   assign last  = pos_ff >= (blen_ff - 32'd1);
   assign early = pos_ff < 32'd3;

   // Per-mode keys
   assign prefix_key = blen_ff[7:0] + pos_ff[7:0];
   assign k0         = seed_ff[8:1];
   assign k1         = {7'd0, seed_ff[0]} + seed_ff[10:3];
   assign pos_ks     = pos_ff[11:4] ^ (pos_ff[7:0] + k0) ^ k1;
   assign inc        = seed_ff[7:0] + seed_ff[23:16];
   assign cur_key    = (pos_ff == 32'd0) ? (seed_ff[15:8] + seed_ff[31:24]) : add_key_ff;

   // Rotating word path: subtract, rotate right, xor seed
   assign word = {item_byte, win_ff[2], win_ff[1], win_ff[0]};
   assign diff = word - (phase_ff ? KEY_B : KEY_A);
   assign rot  = phase_ff ? {diff[4:0], diff[31:5]} : {diff[2:0], diff[31:3]};
   assign dec  = seed_ff ^ rot;

   // Build the result group for the held byte
   always_comb begin
      run_c.data     = {4{item_byte}};
      run_c.last_idx = 2'd0;
      run_c.blk      = last;
      no_result      = 1'b0;
      case (mode_ff)
         MODE_PREFIX: begin
            if (pos_ff < PREFIX_LEN) begin
               run_c.data[0] = item_byte ^ prefix_key;
            end
         end
         MODE_POSKEY: begin
            run_c.data[0] = item_byte ^ pos_ks;
         end
         MODE_ADDKEY: begin
            run_c.data[0] = item_byte ^ cur_key;
         end
         MODE_ROTWORD: begin
            if (early) begin
               // early position: flush held bytes, then this one, if the block ends here
               run_c.data[0] = win_ff[0];
               run_c.data[1] = win_ff[1];
               run_c.data[2] = win_ff[2];
               run_c.data[pos_ff[1:0]] = item_byte;
               run_c.last_idx = pos_ff[1:0];
               no_result = !last;
            end else if (last) begin
               run_c.data     = dec;
               run_c.last_idx = 2'd3;
            end else begin
               run_c.data[0] = dec[7:0];
            end
         end
         default: begin
            run_c.data[0] = item_byte;
         end
      endcase
   end

   assign item_take = item_valid && (out_free || no_result);
   assign run_load  = item_take && !no_result;
   assign run       = run_c;
   assign csr_hit   = csr_we && (csr_index == CSR_MODE || csr_index == CSR_KEY_SEED
                                 || csr_index == CSR_BLOCK_LEN);

   // Advance block state on each taken byte; any register write restarts the block
   always_comb begin
      mode_in    = mode_ff;
      seed_in    = seed_ff;
      blen_in    = blen_ff;
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      add_key_in = add_key_ff;
      win_in     = win_ff;
      if (csr_hit) begin
         case (csr_index)
            CSR_MODE:      mode_in = mode_type'(csr_wdata[1:0]);
            CSR_KEY_SEED:  seed_in = csr_wdata;
            CSR_BLOCK_LEN: blen_in = csr_wdata;
            default:       mode_in = mode_ff;
         endcase
         pos_in   = 32'd0;
         phase_in = 1'b0;
      end else if (item_take) begin
         pos_in = last ? 32'd0 : pos_ff + 32'd1;
         if (mode_ff == MODE_ADDKEY) begin
            add_key_in = cur_key + inc;
         end
         if (mode_ff == MODE_ROTWORD) begin
            if (early) begin
               win_in[pos_ff[1:0]] = item_byte;
            end else begin
               win_in   = dec[31:8];
               phase_in = last ? 1'b0 : !phase_ff;
            end
         end
         if (last) begin
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PREFIX;
         seed_ff  <= 32'd0;
         blen_ff  <= 32'd1;
         pos_ff   <= 32'd0;
         phase_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         seed_ff  <= seed_in;
         blen_ff  <= blen_in;
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
      end
      add_key_ff <= add_key_in;
      win_ff     <= win_in;
   end

endmodule

[rtl/idb_out_stage.sv]
module idb_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             run_load,
   input  idb_pkg::run_type run,
   output logic             out_free,
   idb_rsp_if.source        rsp_if
);
   import idb_pkg::*;

   run_type    run_ff, run_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       fire, final_beat;

   assign fire       = valid_ff && rsp_if.ready;
   assign final_beat = fire && (idx_ff == run_ff.last_idx);
   assign out_free   = !valid_ff || final_beat;

   // Drive the current beat of the held group
   assign rsp_if.valid     = valid_ff;
   assign rsp_if.out_byte  = run_ff.data[idx_ff];
   assign rsp_if.run_end   = idx_ff == run_ff.last_idx;
   assign rsp_if.block_end = (idx_ff == run_ff.last_idx) && run_ff.blk;

   // Load a new group, or advance through the held one
   always_comb begin
      run_in   = run_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (run_load) begin
         run_in   = run;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (final_beat) begin
         valid_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      run_ff <= run_in;
   end

endmodule

[rtl/image_block_descrambler.sv]
// An accepted byte passes from the input register through the decode into the result register.
// Throughput: one byte per cycle while the result port is ready; the decode is one pass.
// A rotating-word block's final byte gives up to four beats, one per cycle while ready, so the
// held input byte waits until the last beat is taken; this is set by the single result port.
// Reset (synchronous, active high): mode 0, seed 0, length 1, position 0, both stages empty.
module image_block_descrambler (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   idb_req_if.sink     req_if,
   idb_rsp_if.source   rsp_if
);
   import idb_pkg::*;

   logic       item_valid;
   logic [7:0] item_byte;
   logic       item_take;
   logic       out_free;
   logic       run_load;
   run_type    run;

   idb_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   idb_descramble u_dsc (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .out_free   (out_free),
      .item_take  (item_take),
      .run_load   (run_load),
      .run        (run)
   );

   idb_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .run_load (run_load),
      .run      (run),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

endmodule
